// ----- hw/rtl/htls_pkg.sv -----
// ----------------------------------------------------------------------------
// htls_pkg
// Shared types and constants of the hash tree layout search unit.
// ----------------------------------------------------------------------------
`default_nettype none

package htls_pkg;

   localparam int unsigned MAX_LEVELS = 16;
   localparam int unsigned LEVEL_CAP  = (MAX_LEVELS < 16) ? MAX_LEVELS : 16;

   localparam int unsigned BLK_W   = 32;                     // block counts
   localparam int unsigned FAN_W   = 9;                      // fanout register
   localparam int unsigned JPL_W   = 8;                      // journal per level
   localparam int unsigned LIDX_W  = 4;                      // level index
   localparam int unsigned LCNT_W  = 5;                      // level count
   localparam int unsigned JB_W    = JPL_W + LCNT_W - 1;     // 16 * 255 fits
   localparam int unsigned HB_W    = BLK_W + 1;
   localparam int unsigned USED_W  = BLK_W + 2;

   localparam int unsigned DIV_STEPS = BLK_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int unsigned ADDR_W = 3;
   localparam int unsigned DATA_W = 32;

   // register indexes
   localparam logic REG_FANOUT = 1'b0;
   localparam logic REG_JPL    = 1'b1;

   typedef struct packed {
      logic [FAN_W-1:0] fanout;   // already clamped to at least 2
      logic [JPL_W-1:0] jpl;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [BLK_W-1:0] dividend;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [BLK_W-1:0] quotient;  // ceiling of dividend / fanout
   } div_rsp_type;

endpackage

`default_nettype wire

// ----- hw/rtl/htls_csr.sv -----
// ----------------------------------------------------------------------------
// htls_csr
// Configuration registers: fanout and journal blocks per level.
// ----------------------------------------------------------------------------
`default_nettype none

module htls_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [htls_pkg::ADDR_W-1:0] paddr,
   input  wire logic [htls_pkg::DATA_W-1:0] pwdata,
   output logic      [htls_pkg::DATA_W-1:0] prdata,
   output logic                             pready,
   output htls_pkg::cfg_type                cfg
);
   import htls_pkg::*;

   logic [FAN_W-1:0] fanout_ff, fanout_in;
   logic [JPL_W-1:0] jpl_ff, jpl_in;
   logic             wr_en;
   logic             reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[2];

   always_comb begin
      fanout_in = fanout_ff;
      jpl_in    = jpl_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_FANOUT: fanout_in = pwdata[FAN_W-1:0];
            REG_JPL:    jpl_in    = pwdata[JPL_W-1:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fanout_ff <= FAN_W'(128);
         jpl_ff    <= JPL_W'(1);
      end else begin
         fanout_ff <= fanout_in;
         jpl_ff    <= jpl_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FANOUT: prdata = DATA_W'(fanout_ff);
         REG_JPL:    prdata = DATA_W'(jpl_ff);
         default:    prdata = '0;
      endcase
   end

   // a fanout below 2 would never converge; treat it as 2
   assign cfg.fanout = (fanout_ff < FAN_W'(2)) ? FAN_W'(2) : fanout_ff;
   assign cfg.jpl    = jpl_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/htls_cdiv.sv -----
// ----------------------------------------------------------------------------
// htls_cdiv
// Shared ceiling divider: restoring radix-2, one quotient bit per cycle,
// then a rounding-up step.
// ----------------------------------------------------------------------------
`default_nettype none

module htls_cdiv (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [htls_pkg::FAN_W-1:0] divisor,
   input  wire htls_pkg::div_req_type      div_req,
   output htls_pkg::div_rsp_type           div_rsp
);
   import htls_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BLK_W-1:0]     quo_ff, quo_in;
   logic [FAN_W-1:0]     rem_ff, rem_in;
   logic [BLK_W-1:0]     res_ff, res_in;
   logic [FAN_W:0]       rem_sh;
   logic                 ge;

   assign rem_sh = {rem_ff, quo_ff[BLK_W-1]};
   assign ge     = rem_sh >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      res_in  = res_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? FAN_W'(rem_sh - {1'b0, divisor}) : rem_sh[FAN_W-1:0];
         quo_in = {quo_ff[BLK_W-2:0], ge};
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         res_in  = quo_ff + BLK_W'(rem_ff != '0);
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = res_ff;

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff && !fin_ff)
      else $error("divider restarted while busy");

   a_done_after_fin: assert property (@(posedge clock) disable iff (reset)
      fin_ff && !div_req.start |=> div_rsp.done)
      else $error("divider result missing");

   a_not_both: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && fin_ff))
      else $error("divider busy and finishing together");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/htls_ctrl.sv -----
// ----------------------------------------------------------------------------
// htls_ctrl
// Search sequencer: binary search over data block counts, tree build per
// candidate through the shared divider, then one transfer per tree level, or a single failed transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module htls_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire htls_pkg::cfg_type           cfg,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [htls_pkg::BLK_W-1:0]  req_total_blocks,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [htls_pkg::LIDX_W-1:0] rsp_level_index,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_level_blocks,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_data_count,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_hash_count,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_journal_blocks,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_pad_count,
   output logic      [htls_pkg::LCNT_W-1:0] rsp_level_count,
   output logic                             rsp_failed,
   output logic                             rsp_last,
   output htls_pkg::div_req_type            div_req,
   input  wire htls_pkg::div_rsp_type       div_rsp
);
   import htls_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CHECK = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_EVAL  = 7'b0001000,
      ST_DONE  = 7'b0010000,
      ST_EDIV  = 7'b0100000,
      ST_EOUT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [BLK_W-1:0]  blocks_ff, blocks_in;
   logic [BLK_W-1:0]  low_ff, low_in;
   logic [BLK_W-1:0]  high_ff, high_in;
   logic [BLK_W-1:0]  mid_ff, mid_in;
   logic [LCNT_W-1:0] lev_ff, lev_in;
   logic [HB_W-1:0]   hb_ff, hb_in;
   logic [JB_W-1:0]   jb_ff, jb_in;
   logic              found_ff, found_in;
   logic [BLK_W-1:0]  best_db_ff, best_db_in;
   logic [BLK_W-1:0]  best_hb_ff, best_hb_in;
   logic [JB_W-1:0]   best_jb_ff, best_jb_in;
   logic [BLK_W-1:0]  best_pad_ff, best_pad_in;
   logic [LCNT_W-1:0] best_lev_ff, best_lev_in;

   logic [LIDX_W-1:0] lidx_ff, lidx_in;
   logic [BLK_W-1:0]  lblk_ff, lblk_in;
   logic [BLK_W-1:0]  odb_ff, odb_in;
   logic [BLK_W-1:0]  ohb_ff, ohb_in;
   logic [BLK_W-1:0]  ojb_ff, ojb_in;
   logic [BLK_W-1:0]  opad_ff, opad_in;
   logic [LCNT_W-1:0] olev_ff, olev_in;
   logic              ofail_ff, ofail_in;
   logic              olast_ff, olast_in;

   logic [BLK_W-1:0]  mid_calc;
   logic              search_on;
   logic [USED_W-1:0] used;
   logic              fits;
   logic [BLK_W-1:0]  pad;

   assign mid_calc  = low_ff + ((high_ff - low_ff) >> 1);
   assign search_on = (high_ff >= low_ff) && (high_ff != '0);
   assign used      = USED_W'(mid_ff) + USED_W'(hb_ff) + USED_W'(jb_ff);
   assign fits      = used <= USED_W'(blocks_ff);
   assign pad       = blocks_ff - used[BLK_W-1:0];

   always_comb begin
      state_in    = state_ff;
      blocks_in   = blocks_ff;
      low_in      = low_ff;
      high_in     = high_ff;
      mid_in      = mid_ff;
      lev_in      = lev_ff;
      hb_in       = hb_ff;
      jb_in       = jb_ff;
      found_in    = found_ff;
      best_db_in  = best_db_ff;
      best_hb_in  = best_hb_ff;
      best_jb_in  = best_jb_ff;
      best_pad_in = best_pad_ff;
      best_lev_in = best_lev_ff;
      lidx_in     = lidx_ff;
      lblk_in     = lblk_ff;
      odb_in      = odb_ff;
      ohb_in      = ohb_ff;
      ojb_in      = ojb_ff;
      opad_in     = opad_ff;
      olev_in     = olev_ff;
      ofail_in    = ofail_ff;
      olast_in    = olast_ff;
      div_req.start    = 1'b0;
      div_req.dividend = mid_calc;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_total_blocks < BLK_W'(2)) begin
                  state_in = ST_DONE;
                  found_in = 1'b0;
               end else begin
                  blocks_in   = req_total_blocks - BLK_W'(1);
                  low_in      = '0;
                  high_in     = req_total_blocks - BLK_W'(1);
                  best_pad_in = req_total_blocks - BLK_W'(1);
                  found_in    = 1'b0;
                  state_in    = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!search_on || mid_calc == '0) begin
               state_in = ST_DONE;
            end else begin
               mid_in           = mid_calc;
               lev_in           = '0;
               hb_in            = '0;
               jb_in            = '0;
               div_req.start    = 1'b1;
               div_req.dividend = mid_calc;
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == BLK_W'(1)) begin
                  // top level reached
                  lev_in   = lev_ff + LCNT_W'(1);
                  hb_in    = hb_ff + HB_W'(1);
                  jb_in    = jb_ff + JB_W'(cfg.jpl);
                  state_in = ST_EVAL;
               end else if (lev_ff >= LCNT_W'(LEVEL_CAP - 1)) begin
                  // tree too tall: candidate counts as too big
                  high_in  = mid_ff - BLK_W'(1);
                  state_in = ST_CHECK;
               end else begin
                  lev_in           = lev_ff + LCNT_W'(1);
                  hb_in            = hb_ff + HB_W'(div_rsp.quotient);
                  jb_in            = jb_ff + JB_W'(cfg.jpl);
                  div_req.start    = 1'b1;
                  div_req.dividend = div_rsp.quotient;
               end
            end
         end
         ST_EVAL: begin
            if (fits && pad < best_pad_ff) begin
               found_in    = 1'b1;
               best_db_in  = mid_ff;
               best_hb_in  = hb_ff[BLK_W-1:0];
               best_jb_in  = jb_ff;
               best_pad_in = pad;
               best_lev_in = lev_ff;
            end
            if (fits && used == USED_W'(blocks_ff)) begin
               state_in = ST_DONE;
            end else if (!fits) begin
               high_in  = mid_ff - BLK_W'(1);
               state_in = ST_CHECK;
            end else begin
               low_in   = mid_ff + BLK_W'(1);
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (found_ff) begin
               lidx_in          = '0;
               div_req.start    = 1'b1;
               div_req.dividend = best_db_ff;
               state_in         = ST_EDIV;
            end else begin
               lidx_in  = '0;
               lblk_in  = '0;
               odb_in   = '0;
               ohb_in   = '0;
               ojb_in   = '0;
               opad_in  = '0;
               olev_in  = '0;
               ofail_in = 1'b1;
               olast_in = 1'b1;
               state_in = ST_EOUT;
            end
         end
         ST_EDIV: begin
            // levels are rebuilt from the chosen data count on the way out
            if (div_rsp.done) begin
               lblk_in  = div_rsp.quotient;
               odb_in   = best_db_ff;
               ohb_in   = best_hb_ff;
               ojb_in   = BLK_W'(best_jb_ff);
               opad_in  = best_pad_ff;
               olev_in  = best_lev_ff;
               ofail_in = 1'b0;
               olast_in = div_rsp.quotient == BLK_W'(1);
               state_in = ST_EOUT;
            end
         end
         ST_EOUT: begin
            if (!rsp_stall) begin
               if (olast_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  lidx_in          = lidx_ff + LIDX_W'(1);
                  div_req.start    = 1'b1;
                  div_req.dividend = lblk_ff;
                  state_in         = ST_EDIV;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         found_ff <= found_in;
      end
      blocks_ff   <= blocks_in;
      low_ff      <= low_in;
      high_ff     <= high_in;
      mid_ff      <= mid_in;
      lev_ff      <= lev_in;
      hb_ff       <= hb_in;
      jb_ff       <= jb_in;
      best_db_ff  <= best_db_in;
      best_hb_ff  <= best_hb_in;
      best_jb_ff  <= best_jb_in;
      best_pad_ff <= best_pad_in;
      best_lev_ff <= best_lev_in;
      lidx_ff     <= lidx_in;
      lblk_ff     <= lblk_in;
      odb_ff      <= odb_in;
      ohb_ff      <= ohb_in;
      ojb_ff      <= ojb_in;
      opad_ff     <= opad_in;
      olev_ff     <= olev_in;
      ofail_ff    <= ofail_in;
      olast_ff    <= olast_in;
   end

   assign req_stall          = state_ff != ST_IDLE;
   assign rsp_valid          = state_ff == ST_EOUT;
   assign rsp_level_index    = lidx_ff;
   assign rsp_level_blocks   = lblk_ff;
   assign rsp_data_count     = odb_ff;
   assign rsp_hash_count     = ohb_ff;
   assign rsp_journal_blocks = ojb_ff;
   assign rsp_pad_count      = opad_ff;
   assign rsp_level_count    = olev_ff;
   assign rsp_failed         = ofail_ff;
   assign rsp_last           = olast_ff;

`ifndef SYNTHESIS
   a_busy_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result is pending");

   a_fail_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_failed |-> rsp_last)
      else $error("failed result not marked last");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_failed |-> LCNT_W'(rsp_level_index) < rsp_level_count)
      else $error("level index beyond level count");

   a_top_is_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_failed && rsp_last |-> rsp_level_blocks == BLK_W'(1))
      else $error("top level not a single block");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last |=> !req_stall)
      else $error("not ready after final transfer");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/hash_tree_layout_search_unit.sv -----
// ----------------------------------------------------------------------------
// hash_tree_layout_search_unit
// Hash tree layout search: picks the data block count that best fills a
// device and reports the hash tree one level per transfer.
// ----------------------------------------------------------------------------
// One input at a time: req_stall stays high from the accepted transfer until
// the final result (rsp_last) has been taken. Every ceiling division runs
// through one shared radix-2 divider; a search step runs one division per
// tree level (a candidate whose tree grows past the level cap stops at that
// point), the search takes up to 32 steps, and output adds one division and
// one transfer per tree level, plus any wait while the result side stalls.
// The default fanout is 128. Devices below two blocks skip the search and
// offer a single failed result by way of the done state.
`default_nettype none

module hash_tree_layout_search_unit (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [htls_pkg::BLK_W-1:0]  req_total_blocks,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [htls_pkg::LIDX_W-1:0] rsp_level_index,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_level_blocks,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_data_count,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_hash_count,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_journal_blocks,
   output logic      [htls_pkg::BLK_W-1:0]  rsp_pad_count,
   output logic      [htls_pkg::LCNT_W-1:0] rsp_level_count,
   output logic                             rsp_failed,
   output logic                             rsp_last,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [htls_pkg::ADDR_W-1:0] paddr,
   input  wire logic [htls_pkg::DATA_W-1:0] pwdata,
   output logic      [htls_pkg::DATA_W-1:0] prdata,
   output logic                             pready
);
   import htls_pkg::*;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   htls_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   htls_cdiv u_cdiv (
      .clock   (clock),
      .reset   (reset),
      .divisor (cfg.fanout),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   htls_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_total_blocks   (req_total_blocks),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_level_index    (rsp_level_index),
      .rsp_level_blocks   (rsp_level_blocks),
      .rsp_data_count     (rsp_data_count),
      .rsp_hash_count     (rsp_hash_count),
      .rsp_journal_blocks (rsp_journal_blocks),
      .rsp_pad_count      (rsp_pad_count),
      .rsp_level_count    (rsp_level_count),
      .rsp_failed         (rsp_failed),
      .rsp_last           (rsp_last),
      .div_req            (div_req),
      .div_rsp            (div_rsp)
   );

endmodule

`default_nettype wire
